/* hw/rtl/pst_pkg.sv */
// Shared types and constants for the prefix-sum tree core.
package pst_pkg;

    // Tree geometry
    localparam int LEAVES  = 1024;
    localparam int LEAF_W  = $clog2(LEAVES);
    localparam int NODE_W  = LEAF_W + 1;
    localparam int NODES   = 2 * LEAVES;

    // Word field widths
    localparam int INDEX_W = 10;
    localparam int DELTA_W = 16;
    localparam int SUM_W   = 32;

    // Command codes
    localparam logic CMD_QUERY = 1'b0;
    localparam logic CMD_ADD   = 1'b1;

    // Microprogram step addresses
    typedef enum logic [2:0] {
        U_DISPATCH,
        U_Q_LEAF,
        U_Q_FIRST,
        U_Q_LOOP,
        U_Q_DONE,
        U_A_RD,
        U_A_LOOP,
        U_END
    } upc_t;

    // Branch conditions
    typedef enum logic [1:0] {
        J_NEXT,
        J_CMD_ADD,
        J_NODE_NZ,
        J_PARENT_NZ
    } jcond_t;

    // Memory address source
    typedef enum logic [1:0] {
        A_NODE,
        A_LEFT,
        A_PARENT
    } asel_t;

    // Accumulator operation
    typedef enum logic [1:0] {
        ACC_HOLD,
        ACC_LOAD,
        ACC_ADD_ODD
    } accop_t;

    // One control word
    typedef struct packed {
        logic   rd;
        asel_t  asel;
        logic   wr;
        accop_t acc_op;
        logic   shift;
        logic   strobe;
        logic   fin;
        jcond_t jcond;
        upc_t   jtarget;
    } ctrl_t;

    // Datapath status seen by the sequencer
    typedef struct packed {
        logic cmd_add;
        logic node_nz;
        logic parent_nz;
    } stat_t;

endpackage

/* hw/rtl/pst_seq.sv */
// Microcoded sequencer: step counter, control store and branch logic.
module pst_seq
    import pst_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  go,
    input  stat_t stat,
    output ctrl_t ctrl,
    output logic  run
);

    // Control store, one word per step
    function automatic ctrl_t ucode(input upc_t pc);
        ctrl_t w;
        w = '0;
        unique case (pc)
            U_DISPATCH:
            begin
                w.jcond   = J_CMD_ADD;
                w.jtarget = U_A_RD;
            end
            U_Q_LEAF:
            begin
                w.rd   = 1'b1;
                w.asel = A_NODE;
            end
            U_Q_FIRST:
            begin
                w.acc_op = ACC_LOAD;
                w.rd     = 1'b1;
                w.asel   = A_LEFT;
                w.shift  = 1'b1;
            end
            U_Q_LOOP:
            begin
                w.acc_op  = ACC_ADD_ODD;
                w.rd      = 1'b1;
                w.asel    = A_LEFT;
                w.shift   = 1'b1;
                w.jcond   = J_NODE_NZ;
                w.jtarget = U_Q_LOOP;
            end
            U_Q_DONE:
            begin
                w.strobe = 1'b1;
                w.fin    = 1'b1;
            end
            U_A_RD:
            begin
                w.rd   = 1'b1;
                w.asel = A_NODE;
            end
            U_A_LOOP:
            begin
                w.wr      = 1'b1;
                w.rd      = 1'b1;
                w.asel    = A_PARENT;
                w.shift   = 1'b1;
                w.jcond   = J_PARENT_NZ;
                w.jtarget = U_A_LOOP;
            end
            U_END:
            begin
                w.fin = 1'b1;
            end
        endcase
        return w;
    endfunction

    upc_t  upc_reg, upc_next;
    logic  run_reg, run_next;
    ctrl_t word;
    logic  take;

    assign word = ucode(upc_reg);
    assign ctrl = run_reg ? word : ctrl_t'('0);
    assign run  = run_reg;

    // Branch decision and next step
    always_comb
    begin
        unique case (word.jcond)
            J_NEXT:      take = 1'b0;
            J_CMD_ADD:   take = stat.cmd_add;
            J_NODE_NZ:   take = stat.node_nz;
            J_PARENT_NZ: take = stat.parent_nz;
        endcase
        upc_next = upc_reg;
        run_next = run_reg;
        if (go)
        begin
            upc_next = U_DISPATCH;
            run_next = 1'b1;
        end
        else if (run_reg)
        begin
            if (word.fin)
                run_next = 1'b0;
            else if (take)
                upc_next = word.jtarget;
            else
                upc_next = upc_t'(3'(upc_reg + 3'd1));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            upc_reg <= U_DISPATCH;
            run_reg <= 1'b0;
        end
        else
        begin
            upc_reg <= upc_next;
            run_reg <= run_next;
        end
    end

endmodule

/* hw/rtl/prefix_sum_tree_core.sv */
// Top level of the prefix-sum tree core: node memory, datapath and sequencer.
//
// Point-update / prefix-sum tree over 1024 leaves held in a 2048 x 32 node
// memory with one read and one write per cycle. A word is taken when start
// is high and busy is low. An add word is dispatched, reads its leaf and then
// walks leaf to root with one read-modify-write per level over 11 levels
// before it finishes; it gives no result. A query word walks the same path
// reading the node left of the path at each level, added where the path node
// is a right child; its sum appears on sum for exactly one cycle with valid
// high, and must be taken then. After reset, busy stays high while the node
// memory is cleared one entry a cycle.
module prefix_sum_tree_core
    import pst_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    output logic                      busy,
    input  logic                      cmd,
    input  logic [INDEX_W-1:0]        index,
    input  logic signed [DELTA_W-1:0] delta,
    output logic                      valid,
    output logic signed [SUM_W-1:0]   sum
);

    ctrl_t ctrl;
    stat_t stat;
    logic  run;
    logic  accept;

    logic [SUM_W-1:0]   mem [NODES];
    logic [SUM_W-1:0]   rdata_reg;
    logic [NODE_W-1:0]  node_reg, node_next;
    logic               cmd_reg;
    logic signed [DELTA_W-1:0] delta_reg;
    logic [SUM_W-1:0]   acc_reg, acc_next;
    logic               odd_reg, odd_next;
    logic [NODE_W-1:0]  clr_cnt_reg, clr_cnt_next;
    logic               clr_busy_reg, clr_busy_next;

    logic [LEAF_W-1:0]  leaf_idx;
    logic [NODE_W-1:0]  rd_addr;
    logic [NODE_W-1:0]  wr_addr;
    logic [SUM_W-1:0]   wr_data;
    logic               wr_en;
    logic [SUM_W-1:0]   delta_ext;

    assign busy     = clr_busy_reg | run;
    assign accept   = start & ~busy;
    assign leaf_idx = LEAF_W'(index);
    assign delta_ext = SUM_W'(delta_reg);

    assign stat.cmd_add   = (cmd_reg == CMD_ADD);
    assign stat.node_nz   = |node_reg;
    assign stat.parent_nz = |node_reg[NODE_W-1:1];

    pst_seq u_seq (
        .clk   (clk),
        .rst_n (rst_n),
        .go    (accept),
        .stat  (stat),
        .ctrl  (ctrl),
        .run   (run)
    );

    // Read address select
    always_comb
    begin
        unique case (ctrl.asel)
            A_NODE:   rd_addr = node_reg;
            A_LEFT:   rd_addr = node_reg - NODE_W'(1);
            A_PARENT: rd_addr = {1'b0, node_reg[NODE_W-1:1]};
            default:  rd_addr = node_reg;
        endcase
    end

    // Write port: clearing pass first, then tree updates
    assign wr_en   = clr_busy_reg | ctrl.wr;
    assign wr_addr = clr_busy_reg ? clr_cnt_reg : node_reg;
    assign wr_data = clr_busy_reg ? '0 : rdata_reg + delta_ext;

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        if (ctrl.rd)
            rdata_reg <= mem[rd_addr];
    end

    // Walk register, accumulator, odd flag
    always_comb
    begin
        node_next = node_reg;
        if (accept)
            node_next = {1'b1, leaf_idx};
        else if (ctrl.shift)
            node_next = {1'b0, node_reg[NODE_W-1:1]};

        odd_next = odd_reg;
        if (ctrl.rd && ctrl.asel == A_LEFT)
            odd_next = node_reg[0];

        unique case (ctrl.acc_op)
            ACC_HOLD:    acc_next = acc_reg;
            ACC_LOAD:    acc_next = rdata_reg;
            ACC_ADD_ODD: acc_next = acc_reg + (odd_reg ? rdata_reg : '0);
            default:     acc_next = acc_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        node_reg <= node_next;
        odd_reg  <= odd_next;
        acc_reg  <= acc_next;
        if (accept)
        begin
            cmd_reg   <= cmd;
            delta_reg <= delta;
        end
    end

    // Clearing pass after reset
    always_comb
    begin
        clr_cnt_next  = clr_cnt_reg;
        clr_busy_next = clr_busy_reg;
        if (clr_busy_reg)
        begin
            clr_cnt_next = clr_cnt_reg + NODE_W'(1);
            if (&clr_cnt_reg)
                clr_busy_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg  <= '0;
            clr_busy_reg <= 1'b1;
        end
        else
        begin
            clr_cnt_reg  <= clr_cnt_next;
            clr_busy_reg <= clr_busy_next;
        end
    end

    // Result
    assign valid = ctrl.strobe;
    assign sum   = acc_reg;

`ifndef NO_ASSERTIONS
    // No result while the memory is being cleared
    a_no_valid_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        clr_busy_reg |-> !valid)
        else $error("result strobe during clearing pass");

    // Results come only from query words
    a_valid_is_query: assert property (@(posedge clk) disable iff (!rst_n)
        valid |-> (cmd_reg == CMD_QUERY))
        else $error("result strobe on an add word");

    // Tree writes come only from add words
    a_wr_is_add: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.wr |-> (cmd_reg == CMD_ADD && !clr_busy_reg))
        else $error("tree write outside an add word");

    // A taken word keeps the core busy in the next cycle
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("busy not raised after a word was taken");
`endif

endmodule
